/* rtl/core/etc_pkg.sv */
// ----------------------------------------------------------------------------
// etc_pkg
// Shared widths, register map and types of the quartic escape-time engine.
// ----------------------------------------------------------------------------
package etc_pkg;

  localparam int FRAC    = 28;            // fraction bits, all values
  localparam int Z_W     = 44;            // running z, Q16.28
  localparam int L_W     = 22;            // low half of a split operand
  localparam int H_W     = Z_W - L_W;     // high half, signed
  localparam int C_W     = 32;            // Q4.28 constants and pixel points
  localparam int STEP_W  = 31;
  localparam int COORD_W = 11;            // pixel index port width
  localparam int RING    = 8;             // register stages in one iteration loop
  localparam int TAG_W   = 4;             // order tag, covers twice the ring
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef logic signed [Z_W-1:0] z_t;
  typedef logic signed [C_W-1:0] c_t;
  typedef logic [2:0]            reg_idx_t;

  localparam reg_idx_t REG_MODE   = 3'd0;
  localparam reg_idx_t REG_JRE    = 3'd1;
  localparam reg_idx_t REG_JIM    = 3'd2;
  localparam reg_idx_t REG_ORG_RE = 3'd3;
  localparam reg_idx_t REG_ORG_IM = 3'd4;
  localparam reg_idx_t REG_STEP   = 3'd5;

  // |re| or |im| above 10 escapes at once
  localparam z_t ESC_BOUND = Z_W'(64'd10 << FRAC);
  // |z|^2 limit of 100 in Q8.56
  localparam logic [64:0] ESC_SUM_LIM = 65'd100 << (2 * FRAC);

  typedef struct packed {
    logic               mode;
    c_t                 julia_re;
    c_t                 julia_im;
    c_t                 origin_re;
    c_t                 origin_im;
    logic [STEP_W-1:0]  pixel_step;
  } cfg_t;

endpackage

/* rtl/core/etc_cfg.sv */
// ----------------------------------------------------------------------------
// etc_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module etc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [etc_pkg::ADDR_W-1:0] paddr,
  input  logic [etc_pkg::DATA_W-1:0] pwdata,
  output logic [etc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output etc_pkg::cfg_t              cfg
);
  import etc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= 1'b1;
      cfg.julia_re   <= '0;
      cfg.julia_im   <= '0;
      cfg.origin_re  <= '0;
      cfg.origin_im  <= '0;
      cfg.pixel_step <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:   cfg.mode       <= pwdata[0];
        REG_JRE:    cfg.julia_re   <= c_t'(pwdata);
        REG_JIM:    cfg.julia_im   <= c_t'(pwdata);
        REG_ORG_RE: cfg.origin_re  <= c_t'(pwdata);
        REG_ORG_IM: cfg.origin_im  <= c_t'(pwdata);
        REG_STEP:   cfg.pixel_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = DATA_W'(cfg.mode);
      REG_JRE:    prdata = cfg.julia_re;
      REG_JIM:    prdata = cfg.julia_im;
      REG_ORG_RE: prdata = cfg.origin_re;
      REG_ORG_IM: prdata = cfg.origin_im;
      REG_STEP:   prdata = DATA_W'(cfg.pixel_step);
      default:    prdata = '0;
    endcase
  end

endmodule

/* rtl/core/etc_entry.sv */
// ----------------------------------------------------------------------------
// etc_entry
// Input stage: holds one pixel word and maps it to its complex point.
// ----------------------------------------------------------------------------
module etc_entry #(
  parameter int COORD_BITS = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  logic [etc_pkg::COORD_W-1:0] px,
  input  logic [etc_pkg::COORD_W-1:0] py,
  input  etc_pkg::cfg_t               cfg,
  input  logic                        insert,
  output logic                        e_valid,
  output etc_pkg::c_t                 pre,
  output etc_pkg::c_t                 pim
);
  import etc_pkg::*;

  localparam int PROD_W = COORD_W + STEP_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [COORD_W-1:0] CMASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  logic [PROD_W-1:0] prod_x, prod_y;
  logic              accept;

  function automatic c_t sat_add(input c_t org, input logic [PROD_W-1:0] p);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(org) + $signed({2'b00, p});
    if (s > SUM_W'(64'sd2147483647))        sat_add = {1'b0, {(C_W-1){1'b1}}};
    else if (s < -SUM_W'(64'sd2147483648))  sat_add = {1'b1, {(C_W-1){1'b0}}};
    else                                    sat_add = s[C_W-1:0];
  endfunction

  assign pix_stall = e_valid & ~insert;
  assign accept    = pix_valid & ~pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (accept) begin
      e_valid <= 1'b1;
    end else if (insert) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x <= PROD_W'(px & CMASK) * PROD_W'(cfg.pixel_step);
      prod_y <= PROD_W'(py & CMASK) * PROD_W'(cfg.pixel_step);
    end
  end

  assign pre = sat_add(cfg.origin_re, prod_x);
  assign pim = sat_add(cfg.origin_im, prod_y);

endmodule

/* rtl/core/etc_sq.sv */
// ----------------------------------------------------------------------------
// etc_sq
// Three-stage complex squarer: split partial products, exact product, floor.
// ----------------------------------------------------------------------------
module etc_sq (
  input  logic        clk,
  input  etc_pkg::z_t x,
  input  etc_pkg::z_t y,
  input  etc_pkg::c_t add_re,
  input  etc_pkg::c_t add_im,
  output etc_pkg::z_t re,
  output etc_pkg::z_t im
);
  import etc_pkg::*;

  localparam int F_W = 2 * Z_W;

  z_t                       a [3];
  z_t                       b [3];
  logic signed [2*H_W-1:0]  p_hh [3];
  logic signed [2*H_W:0]    p_hl [3];
  logic signed [2*H_W:0]    p_lh [3];
  logic [2*L_W-1:0]         p_ll [3];
  logic signed [F_W-1:0]    full [3];

  // operand pairs: x*x, y*y, x*y
  always_comb begin
    a[0] = x; b[0] = x;
    a[1] = y; b[1] = y;
    a[2] = x; b[2] = y;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_hh[i] <= $signed(a[i][Z_W-1:L_W]) * $signed(b[i][Z_W-1:L_W]);
      p_hl[i] <= $signed(a[i][Z_W-1:L_W]) * $signed({1'b0, b[i][L_W-1:0]});
      p_lh[i] <= $signed({1'b0, a[i][L_W-1:0]}) * $signed(b[i][Z_W-1:L_W]);
      p_ll[i] <= a[i][L_W-1:0] * b[i][L_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      full[i] <= (F_W'(p_hh[i]) <<< (2 * L_W))
               + ((F_W'(p_hl[i]) + F_W'(p_lh[i])) <<< L_W)
               + $signed(F_W'(p_ll[i]));
    end
  end

  // floor by taking the bits above the fraction; 2xy takes them one place lower
  always_ff @(posedge clk) begin
    re <= $signed(full[0][FRAC +: Z_W]) - $signed(full[1][FRAC +: Z_W]) + Z_W'(add_re);
    im <= $signed(full[2][FRAC-1 +: Z_W]) + Z_W'(add_im);
  end

endmodule

/* rtl/core/etc_esc.sv */
// ----------------------------------------------------------------------------
// etc_esc
// Escape test stage: bound check and exact |z|^2 against 100.
// ----------------------------------------------------------------------------
module etc_esc (
  input  logic        clk,
  input  etc_pkg::z_t x,
  input  etc_pkg::z_t y,
  output etc_pkg::z_t xo,
  output etc_pkg::z_t yo,
  output logic        esc
);
  import etc_pkg::*;

  z_t          ax_full, ay_full;
  logic [31:0] ax, ay;
  logic [63:0] sqx, sqy;
  logic        big;

  assign ax_full = x[Z_W-1] ? -x : x;
  assign ay_full = y[Z_W-1] ? -y : y;
  // only meaningful when within the bound, where they fit 32 bits
  assign ax = ax_full[31:0];
  assign ay = ay_full[31:0];

  always_ff @(posedge clk) begin
    xo  <= x;
    yo  <= y;
    big <= (x > ESC_BOUND) || (x < -ESC_BOUND) || (y > ESC_BOUND) || (y < -ESC_BOUND);
    sqx <= 64'(ax) * 64'(ax);
    sqy <= 64'(ay) * 64'(ay);
  end

  assign esc = big | (({1'b0, sqx} + {1'b0, sqy}) > ESC_SUM_LIM);

endmodule

/* rtl/core/escape_time_quartic_julia.sv */
// ----------------------------------------------------------------------------
// escape_time_quartic_julia
// Escape-time engine for z <- z^4 + c over a ring of eight register stages.
//
//   channel  | signals                         | word
//   ---------+---------------------------------+--------------------------
//   pixel    | pix_valid, pix_stall            | px, py
//   result   | res_valid, res_stall            | iter_count, in_set
//   config   | psel penable pwrite paddr ...   | 6 registers, 32-bit data
//
// One iteration (two squarings, add c, escape test) takes one pass of the
// 8-stage ring; up to 8 pixels circulate at once.
// Results leave in acceptance order, matched by an order tag.
// Reset is synchronous; it empties the ring, the input and output stages.
// A stalled result holds; finished pixels keep circulating until it drains.
// ----------------------------------------------------------------------------
module escape_time_quartic_julia #(
  parameter int MAX_ITER   = 250,
  parameter int COORD_BITS = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  logic [etc_pkg::COORD_W-1:0] px,
  input  logic [etc_pkg::COORD_W-1:0] py,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [7:0]                  iter_count,
  output logic                        in_set,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [etc_pkg::ADDR_W-1:0]  paddr,
  input  logic [etc_pkg::DATA_W-1:0]  pwdata,
  output logic [etc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import etc_pkg::*;

  localparam int ITER_W = $clog2(MAX_ITER + 1);

  typedef struct packed {
    logic              valid;
    logic              done;
    logic              in_set;
    logic [TAG_W-1:0]  tag;
    logic [ITER_W-1:0] k;
    c_t                cre;
    c_t                cim;
  } meta_t;

  cfg_t             cfg;
  meta_t            meta [RING];
  meta_t            upd, meta0_next;
  logic             e_valid, insert, remove, res_free, esc;
  c_t               pre, pim;
  z_t               z0_x, z0_y, s1_re, s1_im, s2_re, s2_im, ex, ey;
  logic [TAG_W-1:0] in_tag, out_tag;

  etc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  etc_entry #(.COORD_BITS(COORD_BITS)) u_entry (
    .clk, .rst, .pix_valid, .pix_stall, .px, .py, .cfg, .insert, .e_valid,
    .pre, .pim
  );

  etc_sq u_sq1 (
    .clk, .x(z0_x), .y(z0_y), .add_re('0), .add_im('0), .re(s1_re), .im(s1_im)
  );

  etc_sq u_sq2 (
    .clk, .x(s1_re), .y(s1_im), .add_re(meta[5].cre), .add_im(meta[5].cim),
    .re(s2_re), .im(s2_im)
  );

  etc_esc u_esc (
    .clk, .x(s2_re), .y(s2_im), .xo(ex), .yo(ey), .esc
  );

  // close out the iteration of the slot leaving the last stage
  always_comb begin
    upd = meta[7];
    if (meta[7].valid && !meta[7].done) begin
      priority if (esc) begin
        upd.done   = 1'b1;
        upd.in_set = 1'b0;
      end else if (meta[7].k == ITER_W'(MAX_ITER - 1)) begin
        upd.done   = 1'b1;
        upd.in_set = 1'b1;
        upd.k      = ITER_W'(MAX_ITER);
      end else begin
        upd.k = meta[7].k + 1'b1;
      end
    end
  end

  assign res_free = ~res_valid | ~res_stall;
  assign remove   = upd.valid & upd.done & (upd.tag == out_tag) & res_free;
  assign insert   = e_valid & (~upd.valid | remove);

  always_comb begin
    priority if (insert) begin
      meta0_next.valid  = 1'b1;
      meta0_next.done   = 1'b0;
      meta0_next.in_set = 1'b0;
      meta0_next.tag    = in_tag;
      meta0_next.k      = '0;
      meta0_next.cre    = cfg.mode ? pre : cfg.julia_re;
      meta0_next.cim    = cfg.mode ? pim : cfg.julia_im;
    end else if (remove) begin
      meta0_next       = upd;
      meta0_next.valid = 1'b0;
    end else begin
      meta0_next = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING; i++) meta[i].valid <= 1'b0;
    end else begin
      meta[0] <= meta0_next;
      for (int i = 1; i < RING; i++) meta[i] <= meta[i-1];
    end
  end

  always_ff @(posedge clk) begin
    z0_x <= insert ? Z_W'(pre) : ex;
    z0_y <= insert ? Z_W'(pim) : ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag  <= '0;
      out_tag <= '0;
    end else begin
      if (insert) in_tag  <= in_tag + 1'b1;
      if (remove) out_tag <= out_tag + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (remove) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (remove) begin
      iter_count <= 8'(upd.k);
      in_set     <= upd.in_set;
    end
  end

  a_in_set_count: assert property (@(posedge clk) disable iff (rst)
    (upd.valid && upd.done && upd.in_set) |-> upd.k == ITER_W'(MAX_ITER))
    else $error("non-escaping pixel finished with a short count");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> e_valid)
    else $error("pixel stall raised with an empty input stage");

  a_tag_advance: assert property (@(posedge clk) disable iff (rst)
    remove |=> out_tag == $past(out_tag) + 1'b1)
    else $error("order tag did not advance on a result");

endmodule
